[sv/crc32c_pkg.sv]
package crc32c_pkg;

   localparam int ZCOUNT_W = 24;
   localparam int ZSTEP_W  = $clog2(ZCOUNT_W);
   localparam logic [31:0] CRC_POLY   = 32'h82F63B78;
   localparam logic [31:0] CRC_INVERT = 32'hFFFFFFFF;
   localparam logic [3:0]  MAX_BYTES  = 4'd8;

   typedef logic [31:0][31:0]                 mat_type;
   typedef logic [8:0][31:0][31:0]            byte_tab_type;
   typedef logic [ZCOUNT_W-1:0][31:0][31:0]   zop_tab_type;

   typedef struct packed {
      logic               accept;
      logic               step;
      logic [ZSTEP_W-1:0] step_idx;
      logic               emit;
      logic               emit_now;
   } cmd_type;

   function automatic logic [31:0] bit_step(input logic [31:0] r);
      bit_step = {1'b0, r[31:1]} ^ (r[0] ? CRC_POLY : 32'h0);
   endfunction

   function automatic logic [31:0] mat_apply(input mat_type m, input logic [31:0] v);
      logic [31:0] acc;
      acc = '0;
      for (int k = 0; k < 32; k++) begin
         if (v[k]) begin
            acc = acc ^ m[k];
         end
      end
      mat_apply = acc;
   endfunction

   function automatic mat_type mat_mul(input mat_type a, input mat_type b);
      mat_type res;
      for (int k = 0; k < 32; k++) begin
         res[k] = mat_apply(a, b[k]);
      end
      mat_mul = res;
   endfunction

   // one zero byte
   function automatic mat_type byte_op();
      mat_type     res;
      logic [31:0] r;
      for (int k = 0; k < 32; k++) begin
         r = 32'h1 << k;
         for (int s = 0; s < 8; s++) begin
            r = bit_step(r);
         end
         res[k] = r;
      end
      byte_op = res;
   endfunction

   // entry m: m zero bytes
   function automatic byte_tab_type build_byte_tab();
      byte_tab_type t;
      mat_type      op1;
      op1 = byte_op();
      for (int k = 0; k < 32; k++) begin
         t[0][k] = 32'h1 << k;
      end
      for (int m = 1; m < 9; m++) begin
         t[m] = mat_mul(op1, t[m-1]);
      end
      build_byte_tab = t;
   endfunction

   // entry i: 2^i zero bytes
   function automatic zop_tab_type build_zop_tab();
      zop_tab_type t;
      t[0] = byte_op();
      for (int i = 1; i < ZCOUNT_W; i++) begin
         t[i] = mat_mul(t[i-1], t[i-1]);
      end
      build_zop_tab = t;
   endfunction

   localparam byte_tab_type BYTE_TAB = build_byte_tab();
   localparam zop_tab_type  ZOP_TAB  = build_zop_tab();

endpackage

[sv/crc32c_ifs.sv]
interface crc32c_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [63:0]                    data_word;
   logic [3:0]                     valid_bytes;
   logic [crc32c_pkg::ZCOUNT_W-1:0] zero_count;
   logic                           first_item;
   logic                           last_item;

   modport source (output valid, action, data_word, valid_bytes, zero_count, first_item,
                   last_item, input ready);
   modport sink (input valid, action, data_word, valid_bytes, zero_count, first_item,
                 last_item, output ready);
endinterface

interface crc32c_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] crc_result;

   modport source (output valid, crc_result, input ready);
   modport sink (input valid, crc_result, output ready);
endinterface

interface crc32c_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] seed_value;

   modport source (output valid, seed_value, input ready);
   modport sink (input valid, seed_value, output ready);
endinterface

[sv/crc32c_ctrl.sv]
module crc32c_ctrl #(
   parameter int ZERO_LEN_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   input  logic                req_last,
   output logic                req_ready,
   input  logic                out_free,
   output crc32c_pkg::cmd_type cmd
);
   import crc32c_pkg::*;

   localparam int ZSTEPS = (ZERO_LEN_BITS < ZCOUNT_W) ? ZERO_LEN_BITS : ZCOUNT_W;
   localparam logic [ZSTEP_W-1:0] STEP_LAST = ZSTEP_W'(ZSTEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ZERO = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [ZSTEP_W-1:0] step_ff, step_in;
   logic               last_ff, last_in;
   logic               fire;

   assign fire = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.step_idx = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = fire;
            if (fire) begin
               if (req_action) begin
                  step_in  = '0;
                  last_in  = req_last;
                  state_in = ST_ZERO;
               end else if (req_last) begin
                  if (out_free) begin
                     cmd.emit_now = 1'b1;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_ZERO: begin
            cmd.step = 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         last_ff  <= last_in;
      end
   end

endmodule

[sv/crc32c_dp.sv]
module crc32c_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  crc32c_pkg::cmd_type             cmd,
   input  logic                            csr_we,
   input  logic [31:0]                     csr_seed,
   input  logic                            action,
   input  logic [63:0]                     data_word,
   input  logic [3:0]                      valid_bytes,
   input  logic [crc32c_pkg::ZCOUNT_W-1:0] zero_count,
   input  logic                            first_item,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [31:0]                     crc_result,
   output logic                            out_free
);
   import crc32c_pkg::*;

   logic [31:0]         seed_ff, crc_ff, crc_in;
   logic [ZCOUNT_W-1:0] zc_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_crc_ff, rsp_crc_in;
   logic [3:0]          nb;
   logic [31:0]         base, fold, zstep;

   always_comb begin
      nb   = (valid_bytes > MAX_BYTES) ? MAX_BYTES : valid_bytes;
      base = first_item ? (seed_ff ^ CRC_INVERT) : crc_ff;
      fold = mat_apply(BYTE_TAB[nb], base);
      for (int b = 0; b < 8; b++) begin
         for (int t = 0; t < 8; t++) begin
            if ((4'(b) < nb) && data_word[8*b+t]) begin
               fold = fold ^ BYTE_TAB[nb - 4'(b)][t];
            end
         end
      end
      zstep = mat_apply(ZOP_TAB[cmd.step_idx], crc_ff);
   end

   always_comb begin
      priority if (cmd.accept) begin
         crc_in = action ? base : fold;
      end else if (cmd.step && zc_ff[cmd.step_idx]) begin
         crc_in = zstep;
      end else begin
         crc_in = crc_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_crc_in   = rsp_crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit || cmd.emit_now) begin
         rsp_valid_in = 1'b1;
         rsp_crc_in   = (cmd.emit_now ? crc_in : crc_ff) ^ CRC_INVERT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            seed_ff <= csr_seed;
         end
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_ff <= rsp_crc_in;
      if (cmd.accept) begin
         zc_ff <= zero_count;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign crc_result = rsp_crc_ff;

endmodule

[sv/crc32c_word_engine.sv]
// Channel   Dir  Payload                                                    Role
// req_chan  in   action, data_word, valid_bytes, zero_count, first/last     message words
// rsp_chan  out  crc_result                                                 final CRC-32C
// csr_chan  in   seed_value                                                 seed register
//
// Data word: all valid bytes folded by one GF(2) matrix step.
// Zero-extend word: the accepting cycle, then one power-of-two operator per count bit, for
// the low min(ZERO_LEN_BITS, 24) bits of zero_count.
// A last zero-extend word then passes through the emit state to post its result.
// Reset clears the CRC register, the seed and the output valid flag, not the output CRC value.
// Results wait in an output register; a last word stalls only while it is full and not being read.
module crc32c_word_engine #(
   parameter int ZERO_LEN_BITS = 24
) (
   input logic          clock,
   input logic          reset,
   crc32c_req_if.sink   req_chan,
   crc32c_rsp_if.source rsp_chan,
   crc32c_csr_if.sink   csr_chan
);
   import crc32c_pkg::*;

   cmd_type cmd;
   logic    req_ready;
   logic    out_free;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;

   crc32c_ctrl #(
      .ZERO_LEN_BITS (ZERO_LEN_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_last   (req_chan.last_item),
      .req_ready  (req_ready),
      .out_free   (out_free),
      .cmd        (cmd)
   );

   crc32c_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_we      (csr_chan.valid),
      .csr_seed    (csr_chan.seed_value),
      .action      (req_chan.action),
      .data_word   (req_chan.data_word),
      .valid_bytes (req_chan.valid_bytes),
      .zero_count  (req_chan.zero_count),
      .first_item  (req_chan.first_item),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .crc_result  (rsp_chan.crc_result),
      .out_free    (out_free)
   );

`ifndef ASSERT_OFF
   a_data_last_posts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !req_chan.action && req_chan.last_item &&
       (!rsp_chan.valid || rsp_chan.ready)) |=> rsp_chan.valid)
      else $error("final data word did not post a result");

   a_data_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !req_chan.action && !req_chan.last_item)
      |=> req_chan.ready)
      else $error("data word held the engine busy");

   a_zero_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.action) |=> !req_chan.ready)
      else $error("word accepted during zero extension");
`endif

endmodule
